### rtl/core/ppsts_pkg.sv
// ----------------------------------------------------------------------------
// PPS timestamp capture package
// Shared types and constants for the pulse-per-second capture channel.
// ----------------------------------------------------------------------------
package ppsts_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic signed [32:0] NS_PER_SEC = 33'sd1000000000;
  localparam logic [29:0] NSEC_MAX = 30'd999999999;

  localparam logic EDGE_ASSERT = 1'b0;
  localparam logic EDGE_CLEAR = 1'b1;

  localparam int unsigned MODE_CAPTURE_ASSERT = 0;
  localparam int unsigned MODE_CAPTURE_CLEAR = 1;
  localparam int unsigned MODE_OFFSET_ASSERT = 2;
  localparam int unsigned MODE_OFFSET_CLEAR = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHANNEL_ID = 3'd0,
    REG_BOUND_CHANNEL = 3'd1,
    REG_MODE_BITS = 3'd2,
    REG_ASSERT_OFFSET_SEC = 3'd3,
    REG_ASSERT_OFFSET_NSEC = 3'd4,
    REG_CLEAR_OFFSET_SEC = 3'd5,
    REG_CLEAR_OFFSET_NSEC = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [1:0] channel_id;
    logic [2:0] bound_channel;
    logic [3:0] mode_bits;
    logic [31:0] assert_offset_sec;
    logic [30:0] assert_offset_nsec;
    logic [31:0] clear_offset_sec;
    logic [30:0] clear_offset_nsec;
  } cfg_t;

  typedef struct packed {
    logic edge_kind;
    logic [31:0] event_count;
    logic [31:0] now_sec;
    logic [29:0] now_nsec;
    logic [31:0] hw_count;
  } edge_item_t;

endpackage

### rtl/core/ppsts_edge.sv
// ----------------------------------------------------------------------------
// PPS edge detector
// Detects level changes, keeps the per-edge sequence counts and registers
// each edge item for the timestamp stage.
// ----------------------------------------------------------------------------
module ppsts_edge (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   dcd_level,
  input  logic [31:0]            now_sec,
  input  logic [29:0]            now_nsec,
  input  logic [31:0]            hw_count,
  output logic                   edge_valid,
  input  logic                   edge_ready,
  output ppsts_pkg::edge_item_t  edge_item
);

  logic        last_level;
  logic [31:0] assert_events;
  logic [31:0] clear_events;
  logic        in_fire;
  logic        is_edge;
  logic [31:0] assert_events_next;
  logic [31:0] clear_events_next;

  assign in_ready = !edge_valid || edge_ready;
  assign in_fire = in_valid && in_ready;
  assign is_edge = dcd_level != last_level;
  assign assert_events_next = assert_events + 32'd1;
  assign clear_events_next = clear_events + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= 1'b0;
      assert_events <= '0;
      clear_events <= '0;
      edge_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        edge_valid <= in_valid && is_edge;
      end
      if (in_fire && is_edge) begin
        last_level <= dcd_level;
        if (dcd_level) begin
          assert_events <= assert_events_next;
        end else begin
          clear_events <= clear_events_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_edge) begin
      edge_item.edge_kind <= dcd_level ? ppsts_pkg::EDGE_ASSERT : ppsts_pkg::EDGE_CLEAR;
      edge_item.event_count <= dcd_level ? assert_events_next : clear_events_next;
      edge_item.now_sec <= now_sec;
      edge_item.now_nsec <= now_nsec;
      edge_item.hw_count <= hw_count;
    end
  end

`ifndef ASSERT_OFF
  a_edge_loaded: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_edge |=> edge_valid)
    else $error("edge item was not registered");
  a_no_edge_level: assert property (@(posedge clk) disable iff (rst)
    in_fire && !is_edge |=> $stable(last_level))
    else $error("level changed without an edge");
  a_assert_count: assert property (@(posedge clk) disable iff (rst)
    in_fire && dcd_level && !last_level |=>
      assert_events == $past(assert_events) + 32'd1 && $stable(clear_events))
    else $error("assert count did not advance by one");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    edge_valid && !edge_ready |=> edge_valid && $stable(edge_item))
    else $error("stalled edge item changed");
`endif

endmodule

### rtl/core/ppsts_stamp.sv
// ----------------------------------------------------------------------------
// PPS timestamp stage
// Applies the per-edge offset when its mode bit is set, normalizes nanoseconds
// and registers the result item with its discipline flag.
// ----------------------------------------------------------------------------
module ppsts_stamp (
  input  logic                   clk,
  input  logic                   rst,
  input  ppsts_pkg::cfg_t        cfg,
  input  logic                   edge_valid,
  output logic                   edge_ready,
  input  ppsts_pkg::edge_item_t  edge_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   edge_kind,
  output logic [31:0]            event_count,
  output logic [31:0]            stamp_sec,
  output logic [29:0]            stamp_nsec,
  output logic [31:0]            capture_count,
  output logic                   discipline
);

  logic               is_clear;
  logic               use_offset;
  logic               capture;
  logic [31:0]        off_sec;
  logic [30:0]        off_nsec;
  logic signed [32:0] nsec_sum;
  logic signed [32:0] nsec_step;
  logic [31:0]        sec_adj;
  logic [31:0]        sec_next;
  logic [29:0]        nsec_next;
  logic               discipline_next;

  assign edge_ready = !out_valid || out_ready;

  always_comb begin
    is_clear = edge_item.edge_kind == ppsts_pkg::EDGE_CLEAR;
    use_offset = is_clear ? cfg.mode_bits[ppsts_pkg::MODE_OFFSET_CLEAR]
                          : cfg.mode_bits[ppsts_pkg::MODE_OFFSET_ASSERT];
    capture = is_clear ? cfg.mode_bits[ppsts_pkg::MODE_CAPTURE_CLEAR]
                       : cfg.mode_bits[ppsts_pkg::MODE_CAPTURE_ASSERT];
    off_sec = is_clear ? cfg.clear_offset_sec : cfg.assert_offset_sec;
    off_nsec = is_clear ? cfg.clear_offset_nsec : cfg.assert_offset_nsec;

    nsec_sum = $signed({3'b000, edge_item.now_nsec}) + $signed({{2{off_nsec[30]}}, off_nsec});
    if (nsec_sum >= ppsts_pkg::NS_PER_SEC) begin
      nsec_step = nsec_sum - ppsts_pkg::NS_PER_SEC;
      sec_adj = 32'd1;
    end else if (nsec_sum < 33'sd0) begin
      nsec_step = nsec_sum + ppsts_pkg::NS_PER_SEC;
      sec_adj = '1;
    end else begin
      nsec_step = nsec_sum;
      sec_adj = '0;
    end

    if (use_offset) begin
      sec_next = edge_item.now_sec + off_sec + sec_adj;
      if (nsec_step < 33'sd0) begin
        nsec_next = '0;
      end else if (nsec_step >= ppsts_pkg::NS_PER_SEC) begin
        nsec_next = ppsts_pkg::NSEC_MAX;
      end else begin
        nsec_next = nsec_step[29:0];
      end
    end else begin
      sec_next = edge_item.now_sec;
      nsec_next = edge_item.now_nsec;
    end

    discipline_next = capture && (cfg.bound_channel == {1'b0, cfg.channel_id});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (edge_ready) begin
      out_valid <= edge_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (edge_ready && edge_valid) begin
      edge_kind <= edge_item.edge_kind;
      event_count <= edge_item.event_count;
      stamp_sec <= sec_next;
      stamp_nsec <= nsec_next;
      capture_count <= edge_item.hw_count;
      discipline <= discipline_next;
    end
  end

endmodule

### rtl/core/pps_edge_timestamp_capture.sv
// ----------------------------------------------------------------------------
// PPS edge timestamp capture
// One pulse-per-second capture channel with per-edge sequence counts,
// offsets and a clock discipline flag.
// ----------------------------------------------------------------------------
// Each input item carries a sample of the carrier-detect level, the time of
// day and the hardware counter. A sample whose level differs from the last
// one is an edge: rising edges count assert events, falling edges count
// clear events, and each edge yields one result item with the timestamp,
// optionally shifted by that edge's offset, and the latched counter value.
// Samples without an edge produce no result.
// Both data channels use valid and ready. Each result passes the edge register
// after edge detection and the result register after the offset add and
// normalization. One item is accepted every cycle unless the receiver stalls.
// When the receiver stalls, the result register and the edge register hold
// their items and input ready drops once both are full.
// Configuration is written via cfg_we, cfg_index and cfg_data; the user writes
// it only while the channel is idle; the block does not check. Reset clears
// the level and both counts, sets the bound channel to none, all else to zero.
// ----------------------------------------------------------------------------
module pps_edge_timestamp_capture (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ppsts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ppsts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             dcd_level,
  input  logic [31:0]                      now_sec,
  input  logic [29:0]                      now_nsec,
  input  logic [31:0]                      hw_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             edge_kind,
  output logic [31:0]                      event_count,
  output logic [31:0]                      stamp_sec,
  output logic [29:0]                      stamp_nsec,
  output logic [31:0]                      capture_count,
  output logic                             discipline
);

  ppsts_pkg::cfg_t        cfg;
  ppsts_pkg::edge_item_t  edge_item;
  logic                   edge_valid;
  logic                   edge_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_id <= '0;
      cfg.bound_channel <= '1;
      cfg.mode_bits <= '0;
      cfg.assert_offset_sec <= '0;
      cfg.assert_offset_nsec <= '0;
      cfg.clear_offset_sec <= '0;
      cfg.clear_offset_nsec <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppsts_pkg::REG_CHANNEL_ID: begin
          cfg.channel_id <= cfg_data[1:0];
        end
        ppsts_pkg::REG_BOUND_CHANNEL: begin
          cfg.bound_channel <= cfg_data[2:0];
        end
        ppsts_pkg::REG_MODE_BITS: begin
          cfg.mode_bits <= cfg_data[3:0];
        end
        ppsts_pkg::REG_ASSERT_OFFSET_SEC: begin
          cfg.assert_offset_sec <= cfg_data;
        end
        ppsts_pkg::REG_ASSERT_OFFSET_NSEC: begin
          cfg.assert_offset_nsec <= cfg_data[30:0];
        end
        ppsts_pkg::REG_CLEAR_OFFSET_SEC: begin
          cfg.clear_offset_sec <= cfg_data;
        end
        ppsts_pkg::REG_CLEAR_OFFSET_NSEC: begin
          cfg.clear_offset_nsec <= cfg_data[30:0];
        end
        default: begin
        end
      endcase
    end
  end

  ppsts_edge u_edge (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .dcd_level  (dcd_level),
    .now_sec    (now_sec),
    .now_nsec   (now_nsec),
    .hw_count   (hw_count),
    .edge_valid (edge_valid),
    .edge_ready (edge_ready),
    .edge_item  (edge_item)
  );

  ppsts_stamp u_stamp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .edge_valid    (edge_valid),
    .edge_ready    (edge_ready),
    .edge_item     (edge_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .edge_kind     (edge_kind),
    .event_count   (event_count),
    .stamp_sec     (stamp_sec),
    .stamp_nsec    (stamp_nsec),
    .capture_count (capture_count),
    .discipline    (discipline)
  );

endmodule
